// ===== design/pwo_pkg.sv =====
// ----------------------------------------------------------------------------
// pwo_pkg
// Shared constants, codes and wave table functions of the wavetable oscillator.
// ----------------------------------------------------------------------------
package pwo_pkg;

    localparam int NUM_KEYS_DEF    = 32;
    localparam int TABLE_SIZE_DEF  = 1024;
    localparam int PHASE_BITS_DEF  = 24;
    localparam int SAMPLE_BITS     = 16;
    localparam int KEY_BITS        = 5;
    localparam int STEP_BITS       = 24;
    localparam int GAIN_BITS       = 16;
    localparam int SEL_BITS        = 2;

    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_PRESS   = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;
    localparam logic [1:0] FUNC_SPARE   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PRESSED  = 2'd1;
    localparam logic [1:0] ST_RELEASED = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [1:0] WAVE_SINE   = 2'd0;
    localparam logic [1:0] WAVE_SAW    = 2'd1;
    localparam logic [1:0] WAVE_SQUARE = 2'd2;
    localparam logic [1:0] WAVE_SPARE  = 2'd3;

    localparam logic [0:0] REG_WAVE = 1'b0;
    localparam logic [0:0] REG_GAIN = 1'b1;

    localparam longint HALF_PI_Q30 = 64'd1686629713;
    localparam longint SAMPLE_MAX  = 64'd32767;

    // floor division by the series denominators, exact for 32-bit dividends
    localparam int     RECIP_SHIFT = 39;
    localparam longint RECIP_6     = longint'((64'd1 << RECIP_SHIFT) / 6) + 1;
    localparam longint RECIP_20    = longint'((64'd1 << RECIP_SHIFT) / 20) + 1;
    localparam longint RECIP_42    = longint'((64'd1 << RECIP_SHIFT) / 42) + 1;
    localparam longint RECIP_72    = longint'((64'd1 << RECIP_SHIFT) / 72) + 1;
    localparam longint RECIP_110   = longint'((64'd1 << RECIP_SHIFT) / 110) + 1;

    // Quarter-wave sine by Taylor series, evaluated at elaboration or as a
    // constant table. The table size is a power of two.
    function automatic logic signed [15:0] sine_entry(input longint i, input longint n);
        longint      a;
        longint      x;
        longint      x2;
        longint      term;
        longint      sum;
        longint      r;
        longint      recip;
        logic [71:0] prod;
        int          sh;
        logic        neg;
        begin
            sh  = $clog2(n);
            a   = 4 * i;
            neg = 1'b0;
            if (a >= 2 * n)
            begin
                neg = 1'b1;
                a   = a - 2 * n;
            end
            if (a > n)
                a = 2 * n - a;
            x    = (a * HALF_PI_Q30) >>> sh;
            x2   = (x * x) >>> 30;
            term = x;
            sum  = x;
            for (int k = 1; k <= 5; k++)
            begin
                case (k)
                    1:       recip = RECIP_6;
                    2:       recip = RECIP_20;
                    3:       recip = RECIP_42;
                    4:       recip = RECIP_72;
                    default: recip = RECIP_110;
                endcase
                prod = 72'((term * x2) >>> 30) * 72'(recip);
                term = longint'(prod >> RECIP_SHIFT);
                if ((k & 1) == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            if (sum < 0)
                sum = 0;
            r = (sum * SAMPLE_MAX + (64'd1 << 29)) >>> 30;
            if (r > SAMPLE_MAX)
                r = SAMPLE_MAX;
            sine_entry = neg ? 16'(-r) : 16'(r);
        end
    endfunction

    function automatic logic signed [15:0] table_entry(input logic [1:0] sel,
                                                      input longint i,
                                                      input longint n);
        longint s;
        begin
            if (sel == WAVE_SINE)
                table_entry = sine_entry(i, n);
            else if (sel == WAVE_SAW)
            begin
                s = (2 * i * 32768) >>> $clog2(n);
                if (2 * i >= n)
                    s = s - 65536;
                table_entry = 16'(s);
            end
            else if (i > 0 && 2 * i < n)
                table_entry = 16'sd32767;
            else
                table_entry = -16'sd32768;
        end
    endfunction

endpackage

// ===== design/polyphonic_wavetable_oscillator.sv =====
// ----------------------------------------------------------------------------
// polyphonic_wavetable_oscillator
// Polyphonic wavetable oscillator with a packed list of held keys.
// ----------------------------------------------------------------------------
// Usage: items arrive on the s_axis channel, tdata = {key_step, key, func}.
// Results leave on m_axis, tdata = {status, sample}, one per item.
// Write wave_select (0x0) and output_gain (0x4) over APB only while idle;
// the block does not enforce this. From the input transfer to the result:
// a press passes look-up, the write of the list, key and step memories and
// the result register; a release adds a read of the slot and last list
// entry; a refused or unused item goes from look-up to the result register.
// A tick walks the active list, per active key a list read, a phase and step
// read, an add and table read and a write back, then a multiply and a
// bit-serial divide; with no active key it goes from look-up to the result
// register. One item is in flight at a time. Reset clears all control state
// and marks every key released; phases read as zero until the first tick
// writes them. When the receiver stalls, the result is held and no new item
// is taken until it has been transferred, at the earliest in the cycle after.
// ----------------------------------------------------------------------------
module polyphonic_wavetable_oscillator #(
    parameter int NUM_KEYS   = pwo_pkg::NUM_KEYS_DEF,
    parameter int TABLE_SIZE = pwo_pkg::TABLE_SIZE_DEF,
    parameter int PHASE_BITS = pwo_pkg::PHASE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // func[1:0], key[6:2], key_step[30:7]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // sample[15:0], status[17:16]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pwo_pkg::*;

    localparam int KW  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CNW = $clog2(NUM_KEYS + 1);
    localparam int TW  = $clog2(TABLE_SIZE);
    localparam int SW  = SAMPLE_BITS + 7 + 1;
    localparam int NW  = SW + GAIN_BITS + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_PRESS, S_REL_RD, S_REL_WR, S_TRD, S_TADD, S_TWR,
        S_TMUL, S_DIV, S_DWAIT, S_OUT
    } state_t;

    typedef logic signed [SAMPLE_BITS-1:0] wave_t;

    function automatic wave_t [TABLE_SIZE-1:0] build_table(input logic [1:0] sel);
        wave_t [TABLE_SIZE-1:0] t;
        begin
            for (int i = 0; i < TABLE_SIZE; i++)
                t[i] = table_entry(sel, longint'(i), longint'(TABLE_SIZE));
            build_table = t;
        end
    endfunction

    localparam wave_t [TABLE_SIZE-1:0] SINE_T = build_table(WAVE_SINE);
    localparam wave_t [TABLE_SIZE-1:0] SAW_T  = build_table(WAVE_SAW);
    localparam wave_t [TABLE_SIZE-1:0] SQR_T  = build_table(WAVE_SQUARE);

    logic [1:0]            wave_reg;
    logic [GAIN_BITS-1:0]  gain_reg;
    state_t                state_reg;
    logic [1:0]            func_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic [CNW-1:0]        count_reg;
    logic [CNW-1:0]        j_reg;
    logic [NUM_KEYS-1:0]   held_reg;
    logic [NUM_KEYS-1:0]   phase_ok_reg;
    logic signed [SW-1:0]  sum_reg;
    logic signed [NW-1:0]  prod_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [1:0]            status_reg;
    logic                  out_valid_reg;
    logic [KW-1:0]         cur_key_reg;
    logic [KW-1:0]         slot_reg;
    logic [PHASE_BITS-1:0] new_phase_reg;

    // memories
    logic [PHASE_BITS-1:0] phase_mem [NUM_KEYS];
    logic [STEP_BITS-1:0]  step_mem  [NUM_KEYS];
    logic [KW-1:0]         list_mem  [NUM_KEYS];
    logic [KW-1:0]         slot_mem  [NUM_KEYS];

    logic [KW-1:0]         list_raddr;
    logic [KW-1:0]         list_rdata;
    logic [KW-1:0]         slot_raddr;
    logic [KW-1:0]         slot_rdata;
    logic [PHASE_BITS-1:0] phase_rdata;
    logic [STEP_BITS-1:0]  step_rdata;
    logic [KW-1:0]         pk_addr;

    logic                  key_in_range;
    logic [KW-1:0]         key_idx;
    logic [TW-1:0]         tidx;
    wave_t                 wave_rdata;
    logic [PHASE_BITS-1:0] phase_cur;
    logic [PHASE_BITS-1:0] phase_next;
    logic                  div_start;
    logic                  div_done;
    logic signed [NW-1:0]  div_quo;
    logic                  in_xfer;
    logic                  out_xfer;
    logic                  cfg_wr;

    assign key_in_range = (32'(key_reg) < NUM_KEYS);
    assign key_idx      = KW'(key_reg);
    assign in_xfer      = s_axis_tvalid && s_axis_tready;
    assign out_xfer     = m_axis_tvalid && m_axis_tready;
    assign cfg_wr       = psel && penable && pwrite && pready;
    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, status_reg, sample_reg};
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_GAIN) ? {16'd0, gain_reg} : {30'd0, wave_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg <= WAVE_SINE;
            gain_reg <= 16'd32768;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_GAIN)
                gain_reg <= pwdata[GAIN_BITS-1:0];
            else
                wave_reg <= pwdata[1:0];
        end
    end

    always_comb
    begin
        list_raddr = KW'(count_reg - 1'b1);
        if (state_reg == S_LOOK && func_reg == FUNC_TICK)
            list_raddr = KW'(j_reg);
    end
    assign slot_raddr = key_idx;
    // phase and step are fetched while the list entry is taken over
    assign pk_addr    = (state_reg == S_TRD) ? list_rdata : cur_key_reg;

    always_ff @(posedge clk)
    begin
        list_rdata  <= list_mem[list_raddr];
        slot_rdata  <= slot_mem[slot_raddr];
        phase_rdata <= phase_mem[pk_addr];
        step_rdata  <= step_mem[pk_addr];
        if (state_reg == S_PRESS)
        begin
            list_mem[KW'(count_reg)] <= key_idx;
            slot_mem[key_idx]        <= KW'(count_reg);
            step_mem[key_idx]        <= step_reg;
        end
        if (state_reg == S_REL_WR)
        begin
            list_mem[slot_reg]   <= list_rdata;
            slot_mem[list_rdata] <= slot_reg;
        end
        if (state_reg == S_TWR)
            phase_mem[cur_key_reg] <= new_phase_reg;
    end

    assign phase_cur  = phase_ok_reg[cur_key_reg] ? phase_rdata : '0;
    assign phase_next = phase_cur + PHASE_BITS'(step_rdata);
    assign tidx       = phase_next[PHASE_BITS-1 -: TW];

    always_ff @(posedge clk)
    begin
        case (wave_reg)
            WAVE_SINE: wave_rdata <= SINE_T[tidx];
            WAVE_SAW:  wave_rdata <= SAW_T[tidx];
            default:   wave_rdata <= SQR_T[tidx];
        endcase
    end

    assign div_start = (state_reg == S_DIV);

    pwo_div #(.NW(NW), .DW(CNW + 15)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   ((CNW + 15)'(count_reg) << 15),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            held_reg      <= '0;
            phase_ok_reg  <= '0;
            out_valid_reg <= 1'b0;
            j_reg         <= '0;
        end
        else
        begin
            if (out_xfer)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        func_reg  <= s_axis_tdata[1:0];
                        key_reg   <= s_axis_tdata[6:2];
                        step_reg  <= s_axis_tdata[30:7];
                        j_reg     <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    sample_reg <= '0;
                    status_reg <= ST_OK;
                    state_reg  <= S_OUT;
                    case (func_reg)
                        FUNC_TICK:
                            if (count_reg != '0)
                                state_reg <= S_TRD;
                        FUNC_PRESS:
                            if (!key_in_range)
                                status_reg <= ST_FULL;
                            else if (held_reg[key_idx])
                                status_reg <= ST_PRESSED;
                            else if (32'(count_reg) >= NUM_KEYS)
                                status_reg <= ST_FULL;
                            else
                                state_reg <= S_PRESS;
                        FUNC_RELEASE:
                            if (!key_in_range || !held_reg[key_idx])
                                status_reg <= ST_RELEASED;
                            else
                                state_reg <= S_REL_RD;
                        default: ;
                    endcase
                end
                S_PRESS:
                begin
                    held_reg[key_idx] <= 1'b1;
                    count_reg         <= count_reg + 1'b1;
                    state_reg         <= S_OUT;
                end
                S_REL_RD:
                begin
                    slot_reg  <= slot_rdata;
                    state_reg <= S_REL_WR;
                end
                S_REL_WR:
                begin
                    held_reg[key_idx] <= 1'b0;
                    count_reg         <= count_reg - 1'b1;
                    state_reg         <= S_OUT;
                end
                S_TRD:
                begin
                    cur_key_reg <= list_rdata;
                    state_reg   <= S_TADD;
                end
                S_TADD:
                begin
                    new_phase_reg <= phase_next;
                    state_reg     <= S_TWR;
                end
                S_TWR:
                begin
                    phase_ok_reg[cur_key_reg] <= 1'b1;
                    sum_reg <= sum_reg + SW'(wave_rdata);
                    j_reg   <= j_reg + 1'b1;
                    if (j_reg + 1'b1 == count_reg)
                        state_reg <= S_TMUL;
                    else
                        state_reg <= S_LOOK;
                end
                S_TMUL:
                begin
                    prod_reg  <= NW'(sum_reg) * $signed({1'b0, gain_reg});
                    state_reg <= S_DIV;
                end
                S_DIV:
                    state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        if (div_quo > NW'(32767))
                            sample_reg <= 16'h7fff;
                        else if (div_quo < -NW'(32768))
                            sample_reg <= 16'h8000;
                        else
                            sample_reg <= div_quo[15:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= NUM_KEYS) else $error("active count beyond key count");
    a_held_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> $countones(held_reg) == 32'(count_reg))
        else $error("held keys disagree with count");
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_axis_tready) else $error("second item taken while busy");
`endif
endmodule

// ===== design/pwo_div.sv =====
// ----------------------------------------------------------------------------
// pwo_div
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pwo_div #(
    parameter int NW = 40,
    parameter int DW = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic        [DW-1:0] den,
    output logic                 done,
    output logic signed [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] den_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   trial;
    logic [DW:0]   shifted;

    assign shifted = {rem_reg[DW-1:0], q_reg[NW-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NW-1];
            q_reg   <= num[NW-1] ? NW'(-num) : num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!trial[DW])
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                q_reg   <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign quo = neg_reg ? NW'(-q_reg) : q_reg;
endmodule

// ===== tb/polyphonic_wavetable_oscillator_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polyphonic_wavetable_oscillator_checker
// Watches the input and result streams and the register port of the
// oscillator. It keeps its own copy of the key list, phases and registers,
// works out the sample and status of every accepted item, and compares each
// result transfer field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module polyphonic_wavetable_oscillator_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // func[1:0], key[6:2], key_step[30:7]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // sample[15:0], status[17:16]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending,
    output int          checked
);
    import pwo_pkg::*;

    localparam int NKEYS = 32;
    localparam int TSIZE = 1024;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [1:0]         status;
    } mix_result_t;

    mix_result_t expected_mix[$];

    logic signed [15:0] sine_rom   [TSIZE];
    logic signed [15:0] saw_rom    [TSIZE];
    logic signed [15:0] square_rom [TSIZE];

    logic [1:0]  wave_mode;
    logic [15:0] gain;
    logic [23:0] phase     [NKEYS];
    logic [23:0] key_inc   [NKEYS];
    logic [4:0]  held_list [NKEYS];
    logic [4:0]  slot_of   [NKEYS];
    logic        held      [NKEYS];
    int          voices;

    function automatic logic signed [15:0] quarter_sine(input longint idx);
        longint ang;
        longint xq;
        longint xsq;
        longint t;
        longint acc;
        longint rnd;
        logic   flip;
        ang  = 4 * idx;
        flip = 1'b0;
        if (ang >= 2 * TSIZE)
        begin
            flip = 1'b1;
            ang  = ang - 2 * TSIZE;
        end
        if (ang > TSIZE)
            ang = 2 * TSIZE - ang;
        xq  = (ang * 64'd1686629713) / TSIZE;
        xsq = (xq * xq) >> 30;
        t   = xq;
        acc = xq;
        for (int n = 1; n <= 5; n++)
        begin
            t = ((t * xsq) >> 30) / ((2 * n) * (2 * n + 1));
            acc = (n % 2 == 1) ? acc - t : acc + t;
        end
        if (acc < 0)
            acc = 0;
        rnd = (acc * 32767 + (64'd1 << 29)) >> 30;
        if (rnd > 32767)
            rnd = 32767;
        return flip ? 16'(-rnd) : 16'(rnd);
    endfunction

    initial
    begin
        longint s;
        for (int i = 0; i < TSIZE; i++)
        begin
            sine_rom[i] = quarter_sine(i);
            s = (2 * i * 32768) / TSIZE;
            if (2 * i >= TSIZE)
                s = s - 65536;
            saw_rom[i]    = 16'(s);
            square_rom[i] = (i > 0 && 2 * i < TSIZE) ? 16'sd32767 : -16'sd32768;
        end
    end

    function automatic mix_result_t predict_mix(input logic [1:0] fn,
                                                input logic [4:0] k,
                                                input logic [23:0] inc);
        mix_result_t res;
        longint      total;
        longint      quo;
        logic [4:0]  kk;
        logic [4:0]  tail;
        logic [9:0]  idx;
        res.sample = '0;
        res.status = ST_OK;
        if (fn == FUNC_TICK)
        begin
            if (voices > 0)
            begin
                total = 0;
                for (int j = 0; j < voices; j++)
                begin
                    kk        = held_list[j];
                    phase[kk] = phase[kk] + key_inc[kk];
                    idx       = phase[kk][23:14];
                    case (wave_mode)
                        WAVE_SINE: total += sine_rom[idx];
                        WAVE_SAW:  total += saw_rom[idx];
                        default:   total += square_rom[idx];
                    endcase
                end
                quo = (total * longint'(gain)) / (longint'(voices) * 32768);
                if (quo > 32767)
                    quo = 32767;
                if (quo < -32768)
                    quo = -32768;
                res.sample = 16'(quo);
            end
        end
        else if (fn == FUNC_PRESS)
        begin
            if (held[k])
                res.status = ST_PRESSED;
            else if (voices >= NKEYS)
                res.status = ST_FULL;
            else
            begin
                held_list[voices] = k;
                slot_of[k]        = 5'(voices);
                held[k]           = 1'b1;
                key_inc[k]        = inc;
                voices++;
            end
        end
        else if (fn == FUNC_RELEASE)
        begin
            if (!held[k] || voices == 0)
                res.status = ST_RELEASED;
            else
            begin
                tail                = held_list[voices - 1];
                held_list[slot_of[k]] = tail;
                slot_of[tail]       = slot_of[k];
                held[k]             = 1'b0;
                voices--;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mix_result_t want;
        mix_result_t got;
        if (!rst_n)
        begin
            wave_mode  <= WAVE_SINE;
            gain       <= 16'd32768;
            voices     = 0;
            for (int i = 0; i < NKEYS; i++)
            begin
                phase[i] = '0;
                held[i]  = 1'b0;
            end
            expected_mix.delete();
            fail_count <= 0;
            pending    <= 0;
            checked    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.sample = m_axis_tdata[15:0];
                got.status = m_axis_tdata[17:16];
                if (expected_mix.size() == 0)
                begin
                    $display("%0t: unexpected result sample=%0d status=%0d",
                             $time, got.sample, got.status);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_mix.pop_front();
                    if (got.sample !== want.sample || got.status !== want.status)
                    begin
                        $display("%0t: mismatch expected %0d/%0d, got %0d/%0d (sample/status)",
                                 $time, want.sample, want.status, got.sample, got.status);
                        fail_count <= fail_count + 1;
                    end
                    checked <= checked + 1;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_mix.push_back(predict_mix(s_axis_tdata[1:0], s_axis_tdata[6:2],
                                                   s_axis_tdata[30:7]));
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_GAIN)
                    gain <= pwdata[15:0];
                else
                    wave_mode <= pwdata[1:0];
            end
            pending <= expected_mix.size();
        end
    end

endmodule

// ===== tb/polyphonic_wavetable_oscillator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polyphonic_wavetable_oscillator_tb
// Drives key presses, releases and sample ticks into the oscillator under
// several wave and gain settings, with bursty input and a stalling receiver.
// Results are checked by the companion checker module.
// ----------------------------------------------------------------------------
module polyphonic_wavetable_oscillator_tb;
    import pwo_pkg::*;

    localparam logic [2:0] ADDR_WAVE = 3'd0;
    localparam logic [2:0] ADDR_GAIN = 3'd4;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // func[1:0], key[6:2], key_step[30:7]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // sample[15:0], status[17:16]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int checked;
    int cycles;
    int sent;
    int burst_left;
    int settings_done;
    logic key_down [32];

    polyphonic_wavetable_oscillator u_dut (.*);

    polyphonic_wavetable_oscillator_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: alternates free-running and stalling stretches
    always @(posedge clk)
    begin
        if (cycles[9])
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        else if (cycles[8])
            m_axis_tready <= ($urandom_range(0, 9) == 0);
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_item(input logic [1:0] fn, input logic [4:0] k, input logic [23:0] inc);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, inc, k, fn};
        burst_left--;
        sent++;
        if (fn == FUNC_PRESS)
            key_down[k] = 1'b1;
        else if (fn == FUNC_RELEASE)
            key_down[k] = 1'b0;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_done++;
    endtask

    function automatic logic [23:0] rand_inc;
        case ($urandom_range(0, 5))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom_range(1, 4095));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int count);
        int press_w;
        int roll;
        int k;
        press_w = $urandom_range(15, 55);
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            k    = $urandom_range(0, 31);
            if (roll < 2)
                send_item(FUNC_SPARE, 5'(k), 24'($urandom));
            else if (roll < 2 + press_w)
                send_item(FUNC_PRESS, 5'(k), rand_inc());
            else if (roll < 2 + press_w + 20)
            begin
                // prefer a held key so releases mostly succeed
                for (int t = 0; t < 8 && !key_down[k]; t++)
                    k = $urandom_range(0, 31);
                send_item(FUNC_RELEASE, 5'(k), 24'($urandom));
            end
            else
                send_item(FUNC_TICK, 5'(k), 24'($urandom));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b1;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cycles        = 0;
        sent          = 0;
        burst_left    = 0;
        settings_done = 0;
        for (int i = 0; i < 32; i++)
            key_down[i] = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty tick, step extremes, duplicate, unknown release,
        // unused func, release that moves the last entry
        send_item(FUNC_TICK, 5'd0, 24'h0);
        send_item(FUNC_RELEASE, 5'd5, 24'h0);
        send_item(FUNC_PRESS, 5'd0, 24'hFFFFFF);
        send_item(FUNC_PRESS, 5'd31, 24'h000000);
        send_item(FUNC_PRESS, 5'd0, 24'h123456);
        send_item(FUNC_TICK, 5'd31, 24'hFFFFFF);
        send_item(FUNC_SPARE, 5'd31, 24'hFFFFFF);
        send_item(FUNC_PRESS, 5'd10, 24'h400000);
        send_item(FUNC_PRESS, 5'd21, 24'h800000);
        send_item(FUNC_TICK, 5'd0, 24'h0);
        send_item(FUNC_RELEASE, 5'd0, 24'h0);
        send_item(FUNC_TICK, 5'd0, 24'h0);
        send_item(FUNC_RELEASE, 5'd31, 24'h0);
        send_item(FUNC_RELEASE, 5'd31, 24'h0);
        send_item(FUNC_TICK, 5'd0, 24'h0);
        drain();

        random_phase(190);
        drain(); reg_write(ADDR_WAVE, WAVE_SAW);    reg_write(ADDR_GAIN, 32'd65535);
        random_phase(190);
        drain(); reg_write(ADDR_WAVE, WAVE_SQUARE); reg_write(ADDR_GAIN, 32'd0);
        random_phase(190);
        drain(); reg_write(ADDR_WAVE, WAVE_SPARE);  reg_write(ADDR_GAIN, 32'd16384);
        random_phase(190);
        drain(); reg_write(ADDR_WAVE, WAVE_SINE);   reg_write(ADDR_GAIN, 32'd65535);
        random_phase(190);
        drain(); reg_write(ADDR_WAVE, WAVE_SAW);    reg_write(ADDR_GAIN, 32'd1);
        random_phase(190);
        drain(); reg_write(ADDR_WAVE, WAVE_SQUARE); reg_write(ADDR_GAIN, 32'd32768);
        random_phase(190);
        drain(); reg_write(ADDR_WAVE, WAVE_SINE);
        reg_write(ADDR_GAIN, 32'($urandom_range(0, 65535)));
        random_phase(190);
        drain();

        $display("Sent %0d transfers over %0d register writes; %0d results checked.",
                 sent, settings_done, checked);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
